[hw/rtl/htm_read_write_set_tracker_top_defines.svh]
// Assertion macros used by the read/write set tracker RTL.
`ifndef HTM_READ_WRITE_SET_TRACKER_TOP_DEFINES_SVH
`define HTM_READ_WRITE_SET_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// invariant sampled on every clock edge out of reset
`define HTMRW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequence checked in the cycle after the trigger
`define HTMRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HTMRW_ASSERT(lbl, cond, msg)
`define HTMRW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/htm_rwst_pkg.sv]
// Types and constants of the transactional read/write set tracker.
package htm_rwst_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int ADDR_BITS_DEF = 48;
  localparam int KIND_W        = 4;
  localparam int SIZE_W        = 7;
  localparam int CFG_DATA_W    = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int OFFSET_W      = 4;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX      = 4'd12;
  localparam logic [OFFSET_W-1:0] LINE_OFFSET_RST = 4'd6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_READ    = 4'd0,
    KIND_RETIRE_READ = 4'd1,
    KIND_ADD_WRITE   = 4'd2,
    KIND_RM_READ     = 4'd3,
    KIND_RM_WRITE    = 4'd4,
    KIND_REDIRECT    = 4'd5,
    KIND_QUERY       = 4'd6,
    KIND_BEGIN       = 4'd7,
    KIND_CLEAR_ALL   = 4'd8,
    KIND_REL_READ    = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_CHECK   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RS_EXECUTED   = 2'd0,
    RS_OVERTAKING = 2'd1,
    RS_RETIRED    = 2'd2
  } rd_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_OFFSET = 1'd0,
    CFG_PRECISE     = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic                hit_read;
    logic                read_retired;
    logic                read_overtaking;
    logic                hit_write;
    logic                hit_redirect;
    logic [SIZE_W-1:0]   read_set_size;
    logic [SIZE_W-1:0]   write_set_size;
    status_t             status;
  } res_t;

endpackage

[hw/rtl/htm_rwst_if.sv]
// Valid/ready channel interfaces for tracker items and results.
interface htm_rwst_item_if #(
  parameter int ADDR_BITS = htm_rwst_pkg::ADDR_BITS_DEF
);
  import htm_rwst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ADDR_BITS-1:0] address;
  logic                 outside_transaction;

  modport source (output valid, kind, address, outside_transaction, input ready);
  modport sink   (input valid, kind, address, outside_transaction, output ready);
endinterface

interface htm_rwst_result_if;
  import htm_rwst_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit_read;
  logic              read_retired;
  logic              read_overtaking;
  logic              hit_write;
  logic              hit_redirect;
  logic [SIZE_W-1:0] read_set_size;
  logic [SIZE_W-1:0] write_set_size;
  logic [1:0]        status;

  modport source (output valid, hit_read, read_retired, read_overtaking, hit_write,
                  hit_redirect, read_set_size, write_set_size, status, input ready);
  modport sink   (input valid, hit_read, read_retired, read_overtaking, hit_write,
                  hit_redirect, read_set_size, write_set_size, status, output ready);
endinterface

[hw/rtl/htm_rwst_table.sv]
// Fully associative line table: tag match, allocation, mark update and set counts.
`include "htm_read_write_set_tracker_top_defines.svh"

module htm_rwst_table #(
  parameter int ENTRIES   = htm_rwst_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = htm_rwst_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  htm_rwst_pkg::kind_t   kind,
  input  logic [ADDR_BITS-1:0]  line,
  input  logic                  outside,
  input  logic                  precise,
  output htm_rwst_pkg::res_t    res
);
  import htm_rwst_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [ADDR_BITS-1:0] line_tag [ENTRIES];
  logic [ENTRIES-1:0]   read_mark, write_mark, redirect_mark;
  rd_state_t            read_state [ENTRIES];
  logic [CNT_W-1:0]     read_count, write_count;

  logic [ENTRIES-1:0] in_use, match, free_oh, tgt;
  logic [ENTRIES-1:0] read_mark_next, write_mark_next, redirect_mark_next;
  rd_state_t          read_state_next [ENTRIES];
  logic [CNT_W-1:0]   read_count_next, write_count_next;
  logic               hit, has_free, alloc_kind, any_unretired;
  logic               cur_r, cur_w, cur_d, new_r, new_w, new_d;
  rd_state_t          cur_s, new_s;
  status_t            status;

  always_comb begin
    in_use   = read_mark | write_mark | redirect_mark;
    // lowest free entry
    free_oh  = ~in_use & (in_use + ENTRIES'(1));
    has_free = |(~in_use);
    cur_r = 1'b0;
    cur_w = 1'b0;
    cur_d = 1'b0;
    cur_s = RS_EXECUTED;
    any_unretired = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = in_use[i] && (line_tag[i] == line);
      cur_r |= match[i] & read_mark[i];
      cur_w |= match[i] & write_mark[i];
      cur_d |= match[i] & redirect_mark[i];
      cur_s = rd_state_t'(cur_s | ({2{match[i]}} & read_state[i]));
      any_unretired |= read_mark[i] && (read_state[i] != RS_RETIRED);
    end
    hit        = |match;
    alloc_kind = (kind == KIND_ADD_READ) || (kind == KIND_ADD_WRITE) ||
                 (kind == KIND_REDIRECT);
    tgt        = hit ? match : ((alloc_kind && has_free) ? free_oh : '0);

    new_r  = cur_r;
    new_w  = cur_w;
    new_d  = cur_d;
    new_s  = cur_s;
    status = ST_OK;
    read_count_next  = read_count;
    write_count_next = write_count;

    unique case (kind)
      KIND_ADD_READ: begin
        if (!hit && !has_free) begin
          status = ST_FULL;
        end else if (!cur_r) begin
          new_r = 1'b1;
          new_s = outside ? RS_OVERTAKING : RS_EXECUTED;
          read_count_next = read_count + CNT_W'(1);
        end
      end
      KIND_RETIRE_READ: begin
        if (!cur_r) status = ST_MISSING;
        else        new_s = RS_RETIRED;
      end
      KIND_ADD_WRITE: begin
        if (!hit && !has_free) begin
          status = ST_FULL;
        end else if (!cur_w) begin
          new_w = 1'b1;
          write_count_next = write_count + CNT_W'(1);
        end
      end
      KIND_RM_READ: begin
        if (!cur_r) begin
          status = ST_MISSING;
        end else begin
          new_r = 1'b0;
          new_s = RS_EXECUTED;
          read_count_next = read_count - CNT_W'(1);
        end
      end
      KIND_RM_WRITE: begin
        if (!cur_w) begin
          status = ST_MISSING;
        end else begin
          new_w = 1'b0;
          write_count_next = write_count - CNT_W'(1);
        end
      end
      KIND_REDIRECT: begin
        if (!hit && !has_free) status = ST_FULL;
        else                   new_d = 1'b1;
      end
      KIND_QUERY: begin
        if (cur_r && ((precise && cur_s != RS_RETIRED) ||
                      (outside && cur_s == RS_RETIRED)))
          status = ST_CHECK;
      end
      KIND_BEGIN: begin
        new_w = 1'b0;
        write_count_next = '0;
      end
      KIND_CLEAR_ALL: begin
        if (precise && any_unretired) status = ST_CHECK;
        new_r = 1'b0;
        new_w = 1'b0;
        new_d = 1'b0;
        new_s = RS_EXECUTED;
        read_count_next  = '0;
        write_count_next = '0;
      end
      KIND_REL_READ: begin
        new_r = 1'b0;
        new_s = RS_EXECUTED;
        read_count_next = '0;
      end
      default: begin
      end
    endcase

    for (int i = 0; i < ENTRIES; i++) begin
      read_mark_next[i]     = tgt[i] ? new_r : read_mark[i];
      write_mark_next[i]    = tgt[i] ? new_w : write_mark[i];
      redirect_mark_next[i] = tgt[i] ? new_d : redirect_mark[i];
      read_state_next[i]    = tgt[i] ? new_s : read_state[i];
      if (kind == KIND_BEGIN || kind == KIND_CLEAR_ALL) write_mark_next[i] = 1'b0;
      if (kind == KIND_CLEAR_ALL) redirect_mark_next[i] = 1'b0;
      if (kind == KIND_CLEAR_ALL || kind == KIND_REL_READ) begin
        read_mark_next[i]  = 1'b0;
        read_state_next[i] = RS_EXECUTED;
      end
    end

    res.hit_read        = new_r;
    res.read_retired    = new_r && (new_s == RS_RETIRED);
    res.read_overtaking = new_r && (new_s == RS_OVERTAKING);
    res.hit_write       = new_w;
    res.hit_redirect    = new_d;
    res.read_set_size   = SIZE_W'(read_count_next);
    res.write_set_size  = SIZE_W'(write_count_next);
    res.status          = status;
  end

  // tags need no reset: a tag is only compared while its entry is marked
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt[i]) line_tag[i] <= line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_mark     <= '0;
      write_mark    <= '0;
      redirect_mark <= '0;
      read_count    <= '0;
      write_count   <= '0;
      for (int i = 0; i < ENTRIES; i++) read_state[i] <= RS_EXECUTED;
    end else if (en) begin
      read_mark     <= read_mark_next;
      write_mark    <= write_mark_next;
      redirect_mark <= redirect_mark_next;
      read_count    <= read_count_next;
      write_count   <= write_count_next;
      for (int i = 0; i < ENTRIES; i++) read_state[i] <= read_state_next[i];
    end
  end

  `HTMRW_ASSERT(a_match_onehot, $onehot0(match), "line matches more than one live entry")
  `HTMRW_ASSERT(a_read_count, read_count == CNT_W'($countones(read_mark)), "read count drifted")
  `HTMRW_ASSERT(a_write_count, write_count == CNT_W'($countones(write_mark)), "write count drifted")
  `HTMRW_ASSERT_NEXT(a_clear_all, en && kind == KIND_CLEAR_ALL, in_use == '0 && read_count == '0 && write_count == '0, "clear left live entries")
  `HTMRW_ASSERT_NEXT(a_full_hold, en && status == ST_FULL, $stable(read_mark) && $stable(write_mark) && $stable(redirect_mark), "full table changed marks")

endmodule

[hw/rtl/htm_read_write_set_tracker_top.sv]
// Top level of the transactional read/write set tracker.
//
// Usage: each item on the item channel names a kind (add/retire/remove read,
// add/remove write, redirect, query, begin, clear all, release reads), a byte
// address and the outside-transaction flag. The address is reduced to a line
// tag by dropping line_offset_bits low bits (capped at twelve). Every item
// yields exactly one transfer on the result channel: the hit flags of its line
// after the update, the read and write set sizes after the update and a status.
// Pipeline: an accepted item is registered in stage 1, looked up there against
// all entries in parallel, and its result is registered when stage 1 advances.
// Throughput is one item per cycle while the result receiver keeps up, bounded
// by the combinational tag match and update of the entry table.
// When the result receiver stalls, the held result and one pending item stay in
// place and item ready drops until the result is taken; nothing is lost.
// Reset (rst, synchronous) empties both sets, clears the counts and sets the
// line offset to six and precise read tracking off. Configuration writes take
// effect at once; the user makes them only while no item is in flight, and the
// block itself does not enforce this.
module htm_read_write_set_tracker_top #(
  parameter int ENTRIES   = htm_rwst_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = htm_rwst_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [htm_rwst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htm_rwst_pkg::CFG_DATA_W-1:0]   cfg_data,
  htm_rwst_item_if.sink                         item,
  htm_rwst_result_if.source                     result
);
  import htm_rwst_pkg::*;

  logic [OFFSET_W-1:0]  line_offset_bits;
  logic                 precise_read_tracking;

  logic                 s1_valid;
  logic [KIND_W-1:0]    s1_kind;
  logic [ADDR_BITS-1:0] s1_address;
  logic                 s1_outside;

  logic                 advance;
  logic [OFFSET_W-1:0]  shift;
  logic [ADDR_BITS-1:0] line;
  res_t                 res;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset_bits      <= LINE_OFFSET_RST;
      precise_read_tracking <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_OFFSET: line_offset_bits      <= cfg_data;
        CFG_PRECISE:     precise_read_tracking <= cfg_data[0];
      endcase
    end
  end

  // stage 1 moves on when the result register is free or being drained
  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind    <= item.kind;
      s1_address <= item.address;
      s1_outside <= item.outside_transaction;
    end
  end

  assign shift = (line_offset_bits > OFFSET_MAX) ? OFFSET_MAX : line_offset_bits;
  assign line  = s1_address >> shift;

  htm_rwst_table #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .kind    (kind_t'(s1_kind)),
    .line    (line),
    .outside (s1_outside),
    .precise (precise_read_tracking),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.hit_read        <= res.hit_read;
      result.read_retired    <= res.read_retired;
      result.read_overtaking <= res.read_overtaking;
      result.hit_write       <= res.hit_write;
      result.hit_redirect    <= res.hit_redirect;
      result.read_set_size   <= res.read_set_size;
      result.write_set_size  <= res.write_set_size;
      result.status          <= res.status;
    end
  end

endmodule

[verif/htm_read_write_set_tracker_checker.sv]
// Checker for the read/write set tracker: tracks the sets, predicts each result and compares.
`timescale 1ns / 100ps

module htm_read_write_set_tracker_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [htm_rwst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htm_rwst_pkg::CFG_DATA_W-1:0] cfg_data,
  htm_rwst_item_if                            item,
  htm_rwst_result_if                          result,
  output int                                  mismatches,
  output int                                  waiting,
  output int                                  n_checked,
  output int                                  n_full,
  output int                                  n_missing,
  output int                                  n_check
);
  import htm_rwst_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  logic [ADDR_BITS_DEF-1:0] line_tag [SLOTS];
  logic                     rd_mark  [SLOTS];
  rd_state_t                rd_state [SLOTS];
  logic                     wr_mark  [SLOTS];
  logic                     wb_mark  [SLOTS];
  int                       n_reads;
  int                       n_writes;
  logic [OFFSET_W-1:0]      line_offset;
  logic                     precise;

  res_t pending_answers [$];
  res_t got_answer;
  res_t want_answer;

  task automatic report_mismatch(input string what, input logic [6:0] got,
                                 input logic [6:0] want);
    mismatches++;
    $display("%0t result #%0d: %s got %0h want %0h", $time, n_checked, what, got, want);
  endtask

  function automatic int find_line(input logic [ADDR_BITS_DEF-1:0] tag);
    for (int i = 0; i < SLOTS; i++)
      if ((rd_mark[i] || wr_mark[i] || wb_mark[i]) && line_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic int claim_entry(input logic [ADDR_BITS_DEF-1:0] tag);
    int e;
    e = find_line(tag);
    if (e >= 0) return e;
    for (int i = 0; i < SLOTS; i++) begin
      if (!(rd_mark[i] || wr_mark[i] || wb_mark[i])) begin
        line_tag[i] = tag;
        rd_state[i] = RS_EXECUTED;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic res_t track_access(input logic [KIND_W-1:0] kind,
                                        input logic [ADDR_BITS_DEF-1:0] addr,
                                        input logic outside);
    res_t                     r;
    logic [ADDR_BITS_DEF-1:0] tag;
    int                       e;
    int                       sh;
    status_t                  st;
    sh = (line_offset > OFFSET_MAX) ? OFFSET_MAX : line_offset;
    tag = addr >> sh;
    st = ST_OK;
    case (kind)
      KIND_ADD_READ: begin
        e = claim_entry(tag);
        if (e < 0) st = ST_FULL;
        else if (!rd_mark[e]) begin
          rd_mark[e] = 1'b1;
          if (outside) rd_state[e] = RS_OVERTAKING;
          else rd_state[e] = RS_EXECUTED;
          n_reads++;
        end
      end
      KIND_RETIRE_READ: begin
        e = find_line(tag);
        if (e < 0 || !rd_mark[e]) st = ST_MISSING;
        else rd_state[e] = RS_RETIRED;
      end
      KIND_ADD_WRITE: begin
        e = claim_entry(tag);
        if (e < 0) st = ST_FULL;
        else if (!wr_mark[e]) begin
          wr_mark[e] = 1'b1;
          n_writes++;
        end
      end
      KIND_RM_READ: begin
        e = find_line(tag);
        if (e < 0 || !rd_mark[e]) st = ST_MISSING;
        else begin
          rd_mark[e] = 1'b0;
          rd_state[e] = RS_EXECUTED;
          n_reads--;
        end
      end
      KIND_RM_WRITE: begin
        e = find_line(tag);
        if (e < 0 || !wr_mark[e]) st = ST_MISSING;
        else begin
          wr_mark[e] = 1'b0;
          n_writes--;
        end
      end
      KIND_REDIRECT: begin
        e = claim_entry(tag);
        if (e < 0) st = ST_FULL;
        else wb_mark[e] = 1'b1;
      end
      KIND_QUERY: begin
        e = find_line(tag);
        if (e >= 0 && rd_mark[e]) begin
          if (precise && rd_state[e] != RS_RETIRED) st = ST_CHECK;
          if (outside && rd_state[e] == RS_RETIRED) st = ST_CHECK;
        end
      end
      KIND_BEGIN: begin
        for (int i = 0; i < SLOTS; i++) wr_mark[i] = 1'b0;
        n_writes = 0;
      end
      KIND_CLEAR_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (precise && rd_mark[i] && rd_state[i] != RS_RETIRED) st = ST_CHECK;
          rd_mark[i] = 1'b0;
          rd_state[i] = RS_EXECUTED;
          wr_mark[i] = 1'b0;
          wb_mark[i] = 1'b0;
        end
        n_reads = 0;
        n_writes = 0;
      end
      KIND_REL_READ: begin
        for (int i = 0; i < SLOTS; i++) begin
          rd_mark[i] = 1'b0;
          rd_state[i] = RS_EXECUTED;
        end
        n_reads = 0;
      end
      default: ;
    endcase
    r = '0;
    e = find_line(tag);
    if (e >= 0) begin
      r.hit_read = rd_mark[e];
      r.read_retired = rd_mark[e] && rd_state[e] == RS_RETIRED;
      r.read_overtaking = rd_mark[e] && rd_state[e] == RS_OVERTAKING;
      r.hit_write = wr_mark[e];
      r.hit_redirect = wb_mark[e];
    end
    r.read_set_size = 7'(n_reads);
    r.write_set_size = 7'(n_writes);
    r.status = st;
    return r;
  endfunction

  task automatic compare_answer(input res_t got, input res_t want);
    if (got.hit_read !== want.hit_read)
      report_mismatch("hit_read", 7'(got.hit_read), 7'(want.hit_read));
    if (got.read_retired !== want.read_retired)
      report_mismatch("read_retired", 7'(got.read_retired), 7'(want.read_retired));
    if (got.read_overtaking !== want.read_overtaking)
      report_mismatch("read_overtaking", 7'(got.read_overtaking),
                      7'(want.read_overtaking));
    if (got.hit_write !== want.hit_write)
      report_mismatch("hit_write", 7'(got.hit_write), 7'(want.hit_write));
    if (got.hit_redirect !== want.hit_redirect)
      report_mismatch("hit_redirect", 7'(got.hit_redirect), 7'(want.hit_redirect));
    if (got.read_set_size !== want.read_set_size)
      report_mismatch("read_set_size", got.read_set_size, want.read_set_size);
    if (got.write_set_size !== want.write_set_size)
      report_mismatch("write_set_size", got.write_set_size, want.write_set_size);
    if (got.status !== want.status)
      report_mismatch("status", 7'(got.status), 7'(want.status));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        rd_mark[i] = 1'b0;
        rd_state[i] = RS_EXECUTED;
        wr_mark[i] = 1'b0;
        wb_mark[i] = 1'b0;
      end
      n_reads = 0;
      n_writes = 0;
      line_offset = LINE_OFFSET_RST;
      precise = 1'b0;
      pending_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_OFFSET: line_offset = cfg_data[OFFSET_W-1:0];
          CFG_PRECISE:     precise = cfg_data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        pending_answers.insert(pending_answers.size(),
                               track_access(item.kind, item.address,
                                            item.outside_transaction));
      if (result.valid && result.ready) begin
        got_answer = {result.hit_read, result.read_retired, result.read_overtaking,
                      result.hit_write, result.hit_redirect, result.read_set_size,
                      result.write_set_size, result.status};
        if (pending_answers.size() == 0) begin
          report_mismatch("transfer with nothing outstanding", 7'(got_answer.status), '0);
        end else begin
          want_answer = pending_answers.pop_front();
          compare_answer(got_answer, want_answer);
          case (want_answer.status)
            ST_FULL:    n_full++;
            ST_MISSING: n_missing++;
            ST_CHECK:   n_check++;
            default: ;
          endcase
        end
        n_checked++;
      end
    end
    waiting <= pending_answers.size();
  end

endmodule

[verif/htm_read_write_set_tracker_top_tb.sv]
// Testbench top for the read/write set tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module htm_read_write_set_tracker_top_tb;
  import htm_rwst_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_ITEMS = 165;
  localparam int DRAIN_LIMIT = 50000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int                       send_idle_pct;
  int                       take_idle_pct;
  int                       sent;
  logic [OFFSET_W-1:0]      cur_offset;
  logic [ADDR_BITS_DEF-1:0] pool_base;

  int mismatches;
  int waiting;
  int n_checked;
  int n_full;
  int n_missing;
  int n_check;

  htm_rwst_item_if   item_ch ();
  htm_rwst_result_if result_ch ();

  htm_read_write_set_tracker_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  htm_read_write_set_tracker_checker set_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item_ch),
    .result     (result_ch),
    .mismatches (mismatches),
    .waiting    (waiting),
    .n_checked  (n_checked),
    .n_full     (n_full),
    .n_missing  (n_missing),
    .n_check    (n_check)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  function automatic logic [ADDR_BITS_DEF-1:0] rand_addr();
    return ADDR_BITS_DEF'({$urandom, $urandom});
  endfunction

  // line idx of the current pool, with random bits inside the line
  function automatic logic [ADDR_BITS_DEF-1:0] pool_addr(input int idx);
    int                       sh;
    logic [ADDR_BITS_DEF-1:0] low;
    sh = (cur_offset > OFFSET_MAX) ? OFFSET_MAX : cur_offset;
    low = rand_addr() & ((ADDR_BITS_DEF'(1) << sh) - ADDR_BITS_DEF'(1));
    return pool_base + (ADDR_BITS_DEF'(idx) << sh) + low;
  endfunction

  task automatic send(input logic [KIND_W-1:0] kind, input logic [ADDR_BITS_DEF-1:0] addr,
                      input logic outside);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= kind;
    item_ch.address <= addr;
    item_ch.outside_transaction <= outside;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    int spin;
    item_ch.valid <= 1'b0;
    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (waiting != 0 && spin < DRAIN_LIMIT);
  endtask

  task automatic set_config(input logic [OFFSET_W-1:0] offset, input logic precise);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINE_OFFSET;
    cfg_data <= CFG_DATA_W'(offset);
    @(posedge clk);
    cfg_index <= CFG_PRECISE;
    cfg_data <= CFG_DATA_W'(precise);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_offset = offset;
  endtask

  task automatic send_random_op(input int lines);
    int                pick;
    logic [KIND_W-1:0] kind;
    logic              outside;
    if ($urandom_range(9) == 0) begin
      send(KIND_W'($urandom_range(KIND_SPARE_HI)), rand_addr(), 1'($urandom_range(1)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 28) kind = KIND_ADD_READ;
      else if (pick < 46) kind = KIND_ADD_WRITE;
      else if (pick < 60) kind = KIND_RETIRE_READ;
      else if (pick < 70) kind = KIND_QUERY;
      else if (pick < 76) kind = KIND_REDIRECT;
      else if (pick < 82) kind = KIND_RM_READ;
      else if (pick < 88) kind = KIND_RM_WRITE;
      else if (pick < 91) kind = KIND_REL_READ;
      else if (pick < 93) kind = KIND_BEGIN;
      else if (pick < 95) kind = KIND_CLEAR_ALL;
      else kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      outside = ($urandom_range(9) == 0);
      send(kind, pool_addr($urandom_range(lines - 1)), outside);
    end
  endtask

  task automatic run_transaction();
    int lines;
    int pick;
    lines = ($urandom_range(5) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
    if ($urandom_range(3) == 0) pool_base = rand_addr() & ~ADDR_BITS_DEF'(12'hFFF);
    // reads issued before begin arrive as overtaking
    repeat ($urandom_range(2)) send(KIND_ADD_READ, pool_addr($urandom_range(lines - 1)), 1'b1);
    send(KIND_BEGIN, pool_addr(0), 1'b0);
    // big footprint: touch every line first to push the table to full
    if (lines >= 60) begin
      for (int i = 0; i < lines; i++) begin
        pick = $urandom_range(2);
        send((pick == 0) ? KIND_ADD_READ : (pick == 1) ? KIND_ADD_WRITE : KIND_REDIRECT,
             pool_addr(i), 1'b0);
      end
    end
    repeat ($urandom_range(4, 40)) send_random_op(lines);
    pick = $urandom_range(9);
    if (pick < 6) send(KIND_CLEAR_ALL, pool_addr($urandom_range(lines - 1)), 1'b0);
    else if (pick < 7) send(KIND_REL_READ, pool_addr($urandom_range(lines - 1)), 1'b0);
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [OFFSET_W-1:0]      offsets [SEGMENTS];
    logic                     precs   [SEGMENTS];
    logic [ADDR_BITS_DEF-1:0] line_a;
    logic [ADDR_BITS_DEF-1:0] line_b;
    logic [ADDR_BITS_DEF-1:0] line_c;
    int                       target;
    offsets = '{4'd0, 4'd12, 4'd15, 4'd3, 4'd9, 4'd6};
    precs = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    line_a = 48'h1234_5678_9A40;
    line_b = 48'h0000_0000_0080;
    line_c = 48'hABCD_EF01_2300;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LINE_OFFSET;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_QUERY;
    item_ch.address <= '0;
    item_ch.outside_transaction <= 1'b0;
    send_idle_pct = 25;
    take_idle_pct <= 53;
    sent = 0;
    cur_offset = LINE_OFFSET_RST;
    pool_base = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_config(LINE_OFFSET_RST, 1'b0);
    send(KIND_QUERY, '0, 1'b0);
    send(KIND_RETIRE_READ, line_b, 1'b0);
    send(KIND_RM_READ, line_b, 1'b0);
    send(KIND_RM_WRITE, line_b, 1'b0);
    send(KIND_ADD_READ, line_a, 1'b1);
    send(KIND_ADD_READ, line_a | 48'h3F, 1'b0);
    send(KIND_ADD_READ, line_b, 1'b0);
    send(KIND_RETIRE_READ, line_b, 1'b0);
    send(KIND_RETIRE_READ, line_b, 1'b0);
    send(KIND_QUERY, line_b, 1'b1);
    send(KIND_ADD_WRITE, line_a, 1'b0);
    send(KIND_ADD_WRITE, line_a, 1'b0);
    send(KIND_REDIRECT, line_a, 1'b0);
    send(KIND_REDIRECT, line_c, 1'b0);
    send(KIND_RM_WRITE, line_a, 1'b0);
    send(KIND_ADD_WRITE, '1, 1'b1);
    send(KIND_BEGIN, '1, 1'b0);
    send(KIND_RM_READ, line_a, 1'b0);
    send(KIND_SPARE_LO, line_a, 1'b0);
    send(KIND_SPARE_HI, line_c, 1'b1);
    send(KIND_REL_READ, line_b, 1'b0);
    send(KIND_CLEAR_ALL, line_c, 1'b0);
    set_config(LINE_OFFSET_RST, 1'b1);
    send(KIND_ADD_READ, line_a, 1'b0);
    send(KIND_QUERY, line_a, 1'b0);
    send(KIND_CLEAR_ALL, line_a, 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_config(offsets[seg], precs[seg]);
      // swap the stall pressure from segment 2, then run without gaps from segment 4
      if (seg == 2) begin
        send_idle_pct = 53;
        take_idle_pct <= 25;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        take_idle_pct <= 0;
      end
      pool_base = rand_addr() & ~ADDR_BITS_DEF'(12'hFFF);
      target = sent + SEGMENT_ITEMS;
      while (sent < target) run_transaction();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d items over %0d config settings (offsets 0..15, precise on/off).",
             sent, SEGMENTS + 2);
    $display("Checked %0d results: %0d table full, %0d missing line, %0d check failed.",
             n_checked, n_full, n_missing, n_check);
    if (mismatches == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/htm_rwst_pkg.sv
hw/rtl/htm_rwst_if.sv
hw/rtl/htm_rwst_table.sv
hw/rtl/htm_read_write_set_tracker_top.sv
verif/htm_read_write_set_tracker_checker.sv
verif/htm_read_write_set_tracker_top_tb.sv
